// File: hdl/segment_clip_to_frame_assert.svh
// assertion macros for the segment clipper
// used by segment_clip_to_frame; expects clk and rst_n in scope
`ifndef SEGMENT_CLIP_TO_FRAME_ASSERT_SVH
`define SEGMENT_CLIP_TO_FRAME_ASSERT_SVH
`ifndef SYNTH
`define SCTF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment clipper assertion failed");
`define SCTF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment clipper assertion failed");
`else
`define SCTF_ASSERT_IMP(lbl, ante, cons)
`define SCTF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: hdl/sctf_pkg.sv
// shared constants, types and register codes of the segment clipper
// no dependencies
package sctf_pkg;

  localparam int FRAC_BITS   = 4;
  localparam int T_FRAC_BITS = 16;
  localparam int NUM_EDGES   = 4;

  localparam int CW  = 20;               // input coordinate
  localparam int DW  = 21;               // endpoint difference
  localparam int QW  = 22;               // signed distance / direction
  localparam int MW  = 21;               // divider magnitudes
  localparam int FW  = 13;               // frame register
  localparam int LW  = FW + FRAC_BITS;   // edge limit
  localparam int RW  = T_FRAC_BITS + 3;  // signed ratio and t
  localparam int OW  = 16;               // output coordinate
  localparam int PW  = RW + DW;          // t * d product
  localparam int VW  = 24;               // placed coordinate before clamping

  localparam int DIV_STEPS = T_FRAC_BITS + 1;
  localparam int PIPE_LAT  = DIV_STEPS + 5;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic          zero;
    logic          pneg;
    logic          qnn;
    logic          neg;
    logic [MW-1:0] mag;
    logic [MW-1:0] den;
  } edge_cls_t;

  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] ac;
    logic signed [CW-1:0] ar;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [LW-1:0]        max_col;
    logic [LW-1:0]        max_row;
    edge_cls_t [NUM_EDGES-1:0] edg;
  } seg_entry_t;

  typedef struct packed {
    logic                 ok;
    logic signed [CW-1:0] ac;
    logic signed [CW-1:0] ar;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [LW-1:0]        max_col;
    logic [LW-1:0]        max_row;
    logic [NUM_EDGES-1:0] zero;
    logic [NUM_EDGES-1:0] pneg;
    logic [NUM_EDGES-1:0] qnn;
  } seg_side_t;

  typedef struct packed {
    logic                 ok;
    logic signed [RW-1:0] t0;
    logic signed [RW-1:0] t1;
  } clip_t;

endpackage

// File: hdl/sctf_front.sv
// front end: turns a segment and the frame size into per-edge divide jobs
// depends on sctf_pkg
module sctf_front import sctf_pkg::*; (
  input  logic [FW-1:0]        frame_width,
  input  logic [FW-1:0]        frame_height,
  input  logic signed [CW-1:0] a_col,
  input  logic signed [CW-1:0] a_row,
  input  logic signed [CW-1:0] b_col,
  input  logic signed [CW-1:0] b_row,
  output seg_entry_t           entry
);

  logic signed [DW-1:0] dx, dy;
  logic [LW-1:0]        max_col, max_row;
  logic signed [QW-1:0] pv [NUM_EDGES];
  logic signed [QW-1:0] qv [NUM_EDGES];
  logic signed [QW-1:0] pneg_v [NUM_EDGES];
  logic signed [QW-1:0] qneg_v [NUM_EDGES];

  assign dx = $signed({b_col[CW-1], b_col}) - $signed({a_col[CW-1], a_col});
  assign dy = $signed({b_row[CW-1], b_row}) - $signed({a_row[CW-1], a_row});
  assign max_col = {frame_width - FW'(1), {FRAC_BITS{1'b0}}};
  assign max_row = {frame_height - FW'(1), {FRAC_BITS{1'b0}}};

  always_comb begin
    // left, right, top, bottom
    pv[0] = -$signed({dx[DW-1], dx});
    qv[0] = $signed({{(QW-CW){a_col[CW-1]}}, a_col});
    pv[1] = $signed({dx[DW-1], dx});
    qv[1] = $signed({{(QW-LW){1'b0}}, max_col}) - $signed({{(QW-CW){a_col[CW-1]}}, a_col});
    pv[2] = -$signed({dy[DW-1], dy});
    qv[2] = $signed({{(QW-CW){a_row[CW-1]}}, a_row});
    pv[3] = $signed({dy[DW-1], dy});
    qv[3] = $signed({{(QW-LW){1'b0}}, max_row}) - $signed({{(QW-CW){a_row[CW-1]}}, a_row});
    entry.ok      = (frame_width != '0) && (frame_height != '0);
    entry.ac      = a_col;
    entry.ar      = a_row;
    entry.dx      = dx;
    entry.dy      = dy;
    entry.max_col = max_col;
    entry.max_row = max_row;
    for (int k = 0; k < NUM_EDGES; k++) begin
      pneg_v[k] = -pv[k];
      qneg_v[k] = -qv[k];
      entry.edg[k].zero = (pv[k] == '0);
      entry.edg[k].pneg = pv[k][QW-1];
      entry.edg[k].qnn  = !qv[k][QW-1];
      // sign of the scaled numerator seen by the divider
      entry.edg[k].neg  = pv[k][QW-1] ? (!qv[k][QW-1] && (qv[k] != '0)) : qv[k][QW-1];
      entry.edg[k].mag  = qv[k][QW-1] ? qneg_v[k][MW-1:0] : qv[k][MW-1:0];
      entry.edg[k].den  = pv[k][QW-1] ? pneg_v[k][MW-1:0] : pv[k][MW-1:0];
    end
  end

endmodule

// File: hdl/sctf_queue.sv
// two-word queue between front end and back end
// depends on sctf_pkg
module sctf_queue import sctf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  seg_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output seg_entry_t head
);

  seg_entry_t  slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: hdl/sctf_div.sv
// pipelined restoring divider, one quotient bit a stage
// gives floor(mag * 2^T_FRAC_BITS / den) with a saturation flag; depends on sctf_pkg
module sctf_div import sctf_pkg::*; (
  input  logic                 clk,
  input  logic [MW-1:0]        in_mag,
  input  logic [MW-1:0]        in_den,
  input  logic                 in_neg,
  output logic [DIV_STEPS-1:0] out_quo,
  output logic                 out_rem_nz,
  output logic                 out_neg,
  output logic                 out_sat
);

  logic [MW-1:0]        rem_r   [DIV_STEPS];
  logic [MW-1:0]        rem_nxt [DIV_STEPS];
  logic [MW-1:0]        den_r   [DIV_STEPS];
  logic [MW-1:0]        den_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0] sat_r, sat_nxt;
  logic [DIV_STEPS-1:0] neg_r, neg_nxt;
  logic [MW:0]          rem2    [DIV_STEPS];
  logic [DIV_STEPS-1:0] ge;

  always_comb begin
    // first stage: integer bit, plus overflow when the integer part is two or more
    rem2[0]    = {1'b0, in_mag};
    ge[0]      = in_mag >= in_den;
    rem_nxt[0] = ge[0] ? (in_mag - in_den) : in_mag;
    quo_nxt[0] = {{(DIV_STEPS-1){1'b0}}, ge[0]};
    den_nxt[0] = in_den;
    sat_nxt[0] = {1'b0, in_mag} >= {in_den, 1'b0};
    neg_nxt[0] = in_neg;
    for (int s = 1; s < DIV_STEPS; s++) begin
      rem2[s]    = {rem_r[s-1], 1'b0};
      ge[s]      = rem2[s] >= {1'b0, den_r[s-1]};
      rem_nxt[s] = ge[s] ? MW'(rem2[s] - {1'b0, den_r[s-1]}) : rem2[s][MW-1:0];
      quo_nxt[s] = {quo_r[s-1][DIV_STEPS-2:0], ge[s]};
      den_nxt[s] = den_r[s-1];
      sat_nxt[s] = sat_r[s-1];
      neg_nxt[s] = neg_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_r[s] <= rem_nxt[s];
      den_r[s] <= den_nxt[s];
      quo_r[s] <= quo_nxt[s];
      sat_r[s] <= sat_nxt[s];
      neg_r[s] <= neg_nxt[s];
    end
  end

  assign out_quo    = quo_r[DIV_STEPS-1];
  assign out_rem_nz = (rem_r[DIV_STEPS-1] != '0);
  assign out_neg    = neg_r[DIV_STEPS-1];
  assign out_sat    = sat_r[DIV_STEPS-1];

endmodule

// File: hdl/sctf_back.sv
// back end: edge ratios, entry/exit update, endpoint placement and clamping
// depends on sctf_pkg and sctf_div
module sctf_back import sctf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  seg_entry_t     in_entry,
  output logic           res_valid,
  output logic           res_inside,
  output logic [OW-1:0]  res_a_col,
  output logic [OW-1:0]  res_a_row,
  output logic [OW-1:0]  res_b_col,
  output logic [OW-1:0]  res_b_row
);

  localparam logic signed [RW-1:0] T_ONE    = RW'(1) <<< T_FRAC_BITS;
  localparam logic signed [RW-1:0] T_ABOVE  = (RW'(1) <<< T_FRAC_BITS) + RW'(1);
  localparam logic signed [RW-1:0] T_BELOW  = -RW'(1);
  localparam logic signed [PW:0]   HALF     = (PW+1)'(1) <<< (T_FRAC_BITS - 1);

  function automatic clip_t edge_step(input clip_t c, input logic zero, input logic pneg,
                                      input logic qnn, input logic signed [RW-1:0] r);
    clip_t o;
    o = c;
    if (c.ok) begin
      if (zero) begin
        o.ok = qnn;
      end else if (pneg) begin
        if (r > c.t1) begin
          o.ok = 1'b0;
        end else if (r > c.t0) begin
          o.t0 = r;
        end
      end else begin
        if (r < c.t0) begin
          o.ok = 1'b0;
        end else if (r < c.t1) begin
          o.t1 = r;
        end
      end
    end
    return o;
  endfunction

  function automatic logic [OW-1:0] place(input logic signed [CW-1:0] a,
                                          input logic signed [PW-1:0] prod,
                                          input logic [LW-1:0] lim);
    logic signed [PW:0]   sum;
    logic signed [PW:0]   sh;
    logic signed [VW-1:0] v;
    logic [OW-1:0]        o;
    sum = $signed({prod[PW-1], prod}) + HALF;
    sh  = sum >>> T_FRAC_BITS;
    v   = $signed({{(VW-CW){a[CW-1]}}, a}) + sh[VW-1:0];
    if (v[VW-1]) begin
      o = '0;
    end else if (v > $signed({{(VW-LW){1'b0}}, lim})) begin
      o = (lim > LW'({OW{1'b1}})) ? {OW{1'b1}} : lim[OW-1:0];
    end else if (v > $signed({{(VW-OW){1'b0}}, {OW{1'b1}}})) begin
      o = {OW{1'b1}};
    end else begin
      o = v[OW-1:0];
    end
    return o;
  endfunction

  logic [DIV_STEPS-1:0] d_quo    [NUM_EDGES];
  logic [NUM_EDGES-1:0] d_rem_nz, d_neg, d_sat;

  for (genvar k = 0; k < NUM_EDGES; k++) begin : g_div
    sctf_div u_div (
      .clk        (clk),
      .in_mag     (in_entry.edg[k].mag),
      .in_den     (in_entry.edg[k].den),
      .in_neg     (in_entry.edg[k].neg),
      .out_quo    (d_quo[k]),
      .out_rem_nz (d_rem_nz[k]),
      .out_neg    (d_neg[k]),
      .out_sat    (d_sat[k])
    );
  end

  // side data travels beside the dividers
  seg_side_t            side_r [DIV_STEPS];
  logic [DIV_STEPS-1:0] vld_r;
  seg_side_t            side_in;

  always_comb begin
    side_in.ok      = in_entry.ok;
    side_in.ac      = in_entry.ac;
    side_in.ar      = in_entry.ar;
    side_in.dx      = in_entry.dx;
    side_in.dy      = in_entry.dy;
    side_in.max_col = in_entry.max_col;
    side_in.max_row = in_entry.max_row;
    for (int k = 0; k < NUM_EDGES; k++) begin
      side_in.zero[k] = in_entry.edg[k].zero;
      side_in.pneg[k] = in_entry.edg[k].pneg;
      side_in.qnn[k]  = in_entry.edg[k].qnn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int s = 1; s < DIV_STEPS; s++) begin
      side_r[s] <= side_r[s-1];
    end
  end

  // signed floored ratio per edge
  logic signed [RW-1:0] ratio  [NUM_EDGES];
  logic signed [RW-1:0] quo_s  [NUM_EDGES];
  seg_side_t            sd;
  clip_t                a_c0, a_c1, a_c2;

  assign sd = side_r[DIV_STEPS-1];

  always_comb begin
    for (int k = 0; k < NUM_EDGES; k++) begin
      quo_s[k] = $signed({{(RW-DIV_STEPS){1'b0}}, d_quo[k]});
      if (d_sat[k]) begin
        ratio[k] = d_neg[k] ? T_BELOW : T_ABOVE;
      end else if (d_neg[k]) begin
        ratio[k] = -(quo_s[k] + $signed({{(RW-1){1'b0}}, d_rem_nz[k]}));
      end else begin
        ratio[k] = quo_s[k];
      end
    end
    a_c0.ok = sd.ok;
    a_c0.t0 = '0;
    a_c0.t1 = T_ONE;
    a_c1 = edge_step(a_c0, sd.zero[0], sd.pneg[0], sd.qnn[0], ratio[0]);
    a_c2 = edge_step(a_c1, sd.zero[1], sd.pneg[1], sd.qnn[1], ratio[1]);
  end

  // stage a: left and right edges done
  clip_t                a_clip_r;
  logic signed [RW-1:0] a_r2_r, a_r3_r;
  seg_side_t            a_side_r;
  logic                 a_vld_r;
  // stage b: top and bottom edges done
  clip_t                b_clip_r;
  seg_side_t            b_side_r;
  logic                 b_vld_r;
  clip_t                b_c1, b_c2;
  // stage c: products
  logic signed [PW-1:0] c_a_col_r, c_a_row_r, c_b_col_r, c_b_row_r;
  logic                 c_ok_r;
  seg_side_t            c_side_r;
  logic                 c_vld_r;

  always_comb begin
    b_c1 = edge_step(a_clip_r, a_side_r.zero[2], a_side_r.pneg[2], a_side_r.qnn[2], a_r2_r);
    b_c2 = edge_step(b_c1, a_side_r.zero[3], a_side_r.pneg[3], a_side_r.qnn[3], a_r3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      c_vld_r   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      a_vld_r   <= vld_r[DIV_STEPS-1];
      b_vld_r   <= a_vld_r;
      c_vld_r   <= b_vld_r;
      res_valid <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_clip_r  <= a_c2;
    a_r2_r    <= ratio[2];
    a_r3_r    <= ratio[3];
    a_side_r  <= sd;
    b_clip_r  <= b_c2;
    b_side_r  <= a_side_r;
    c_a_col_r <= b_clip_r.t0 * b_side_r.dx;
    c_a_row_r <= b_clip_r.t0 * b_side_r.dy;
    c_b_col_r <= b_clip_r.t1 * b_side_r.dx;
    c_b_row_r <= b_clip_r.t1 * b_side_r.dy;
    c_ok_r    <= b_clip_r.ok;
    c_side_r  <= b_side_r;
    res_inside <= c_ok_r;
    if (c_ok_r) begin
      res_a_col <= place(c_side_r.ac, c_a_col_r, c_side_r.max_col);
      res_a_row <= place(c_side_r.ar, c_a_row_r, c_side_r.max_row);
      res_b_col <= place(c_side_r.ac, c_b_col_r, c_side_r.max_col);
      res_b_row <= place(c_side_r.ar, c_b_row_r, c_side_r.max_row);
    end else begin
      res_a_col <= '0;
      res_a_row <= '0;
      res_b_col <= '0;
      res_b_row <= '0;
    end
  end

endmodule

// File: hdl/segment_clip_to_frame.sv
// top level of the segment clipper: frame registers, front end, queue, back end
// depends on sctf_pkg, sctf_front, sctf_queue, sctf_back and the assertion header
//
//  channel   handshake                 word
//  input     start / busy              in_a_col, in_a_row, in_b_col, in_b_row
//  result    out_valid (one cycle)     out_inside_res, out_a_col .. out_b_row
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one segment a cycle; a result passes from its accept edge through the queue slot,
// the divider pipeline, the edge-update stages, the multiply stage and the placement stage.
// busy rises only if the queue fills; the back end drains it every cycle.
// synchronous active-low reset clears pipeline valids and queue, and sets frame size to 320 x 240.
// config writes always taken (cfg_ready high); indexes beyond the two registers are dropped.
`include "segment_clip_to_frame_assert.svh"
module segment_clip_to_frame import sctf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [CW-1:0] in_a_col,
  input  logic signed [CW-1:0] in_a_row,
  input  logic signed [CW-1:0] in_b_col,
  input  logic signed [CW-1:0] in_b_row,
  output logic                 out_valid,
  output logic                 out_inside_res,
  output logic [OW-1:0]        out_a_col,
  output logic [OW-1:0]        out_a_row,
  output logic [OW-1:0]        out_b_col,
  output logic [OW-1:0]        out_b_row,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [FW-1:0]        cfg_data
);

  logic [FW-1:0] frame_width_r, frame_width_nxt;
  logic [FW-1:0] frame_height_r, frame_height_nxt;
  seg_entry_t    front_entry, head_entry;
  logic          push, q_full, q_ne;
  logic [LW-1:0] lim_col, lim_row;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;
  assign push      = start && !busy;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW'(320);
      frame_height_r <= FW'(240);
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  sctf_front u_front (
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .a_col        (in_a_col),
    .a_row        (in_a_row),
    .b_col        (in_b_col),
    .b_row        (in_b_row),
    .entry        (front_entry)
  );

  sctf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .pop        (q_ne),
    .full       (q_full),
    .not_empty  (q_ne),
    .head       (head_entry)
  );

  sctf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (q_ne),
    .in_entry   (head_entry),
    .res_valid  (out_valid),
    .res_inside (out_inside_res),
    .res_a_col  (out_a_col),
    .res_a_row  (out_a_row),
    .res_b_col  (out_b_col),
    .res_b_row  (out_b_row)
  );

  assign lim_col = {frame_width_r - FW'(1), {FRAC_BITS{1'b0}}};
  assign lim_row = {frame_height_r - FW'(1), {FRAC_BITS{1'b0}}};

  `SCTF_ASSERT_IMP(a_zero_when_outside, out_valid && !out_inside_res, (out_a_col == '0) && (out_a_row == '0) && (out_b_col == '0) && (out_b_row == '0))
  `SCTF_ASSERT_IMP(a_inside_in_frame, out_valid && out_inside_res, ({1'b0, out_a_col} <= lim_col) && ({1'b0, out_b_col} <= lim_col) && ({1'b0, out_a_row} <= lim_row) && ({1'b0, out_b_row} <= lim_row))
  `SCTF_ASSERT_IMP(a_result_latency, start && !busy, ##PIPE_LAT out_valid)
  `SCTF_ASSERT_NXT(a_queue_drains, start && !busy, !busy)

endmodule
